### design/kmne_pkg.sv
// Shared constants and types for the key matrix MIDI note encoder.
package kmne_pkg;

  localparam int PIN_COUNT_DEF  = 10;
  localparam int NOTE_COUNT_DEF = 88;

  localparam int KEY_IN_W = 7;
  localparam int NOTE_W   = 7;

  // input selector codes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_LEARN  = 2'd2;

  // configuration register indexes
  localparam logic REG_MIDI_CHANNEL  = 1'b0;
  localparam logic REG_NOTE_VELOCITY = 1'b1;

  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] PITCH_OFFSET    = 8'd21;
  localparam logic [6:0] VELOCITY_RESET  = 7'd10;

  // notes skipped while learning (pitches 23, 49, 82)
  localparam logic [7:0] SKIP_NOTE_A = 8'd2;
  localparam logic [7:0] SKIP_NOTE_B = 8'd28;
  localparam logic [7:0] SKIP_NOTE_C = 8'd61;

  localparam logic KIND_MIDI   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef struct packed {
    logic              level;
    logic [NOTE_W-1:0] note;
  } key_entry_t;

endpackage

### design/key_matrix_midi_note_encoder_core.sv
// Key matrix to MIDI note encoder: key state memory, read-modify-write pipe and byte emitter.
//
// Input channel in_*: one word per key sample, map load or learn start (in_tuser = mode).
// Output channel out_*: MIDI bytes (out_tuser = 0) or learned mapping records (out_tuser = 1),
// out_tlast marks the final word caused by an input word.
// Configuration: cfg_we with cfg_index 0 sets the MIDI channel, 1 sets the velocity.
//
// Pipeline: an accepted word reads the key memory into a register, then the modify stage
// modifies the entry and writes it back, forwarding a write to the same key from the word
// just before. The first result word is registered in the emitter when the modify stage
// fires. Words that cause no result go through at one per cycle while the modify stage is
// not held. A note event gives three output words; a word that would emit waits in the
// modify stage until the previous event's last word is being taken, since all events share
// the single output port. A learned record gives one output word.
// Reset clears all key levels and mappings at once through per-key flags; no sweep is
// needed. When the receiver stalls, the output word holds, a word in the modify stage
// that would emit waits, and in_tready drops while such a word is held there.
module key_matrix_midi_note_encoder_core
  import kmne_pkg::*;
#(
  parameter int PIN_COUNT  = PIN_COUNT_DEF,
  parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // key_index[6:0], level[7], note_index[14:8]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // byte_value[7:0], map_key[14:8], map_note[21:15]
  output logic        out_tuser,  // kind[0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);

  localparam int KEY_COUNT = PIN_COUNT * (PIN_COUNT - 1);
  localparam int KEY_W     = $clog2(KEY_COUNT);

  // configuration
  logic [3:0] chan_r;
  logic [6:0] vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= 4'd0;
      vel_r  <= VELOCITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIDI_CHANNEL:  chan_r <= cfg_wdata[3:0];
        REG_NOTE_VELOCITY: vel_r  <= cfg_wdata;
      endcase
    end
  end

  // input fields
  logic [KEY_IN_W-1:0] in_key;
  logic                in_lvl;
  logic [NOTE_W-1:0]   in_note;
  logic                in_acc;
  logic                in_key_ok;
  logic [KEY_W-1:0]    in_a;

  assign in_key    = in_tdata[6:0];
  assign in_lvl    = in_tdata[7];
  assign in_note   = in_tdata[14:8];
  assign in_acc    = in_tvalid && in_tready;
  assign in_key_ok = {1'b0, in_key} < 8'(KEY_COUNT);
  assign in_a      = KEY_W'(in_key);

  // key memory and per-key flags
  key_entry_t                 mem [KEY_COUNT];
  key_entry_t                 mem_rd_r;
  logic [KEY_COUNT-1:0]       vld_r;
  logic [KEY_COUNT-1:0]       mapped_r;
  logic                       mem_we;
  key_entry_t                 wr_data;

  // modify stage
  logic                s1_v_r;
  logic [1:0]          s1_mode_r;
  logic [KEY_IN_W-1:0] s1_key_r;
  logic                s1_lvl_r;
  logic [NOTE_W-1:0]   s1_note_r;
  logic                s1_key_ok_r;
  logic                s1_hit_r;
  key_entry_t          fwd_r;
  logic [KEY_W-1:0]    s1_a;
  logic                s1_fire;

  logic                learning_r;
  logic [NOTE_W-1:0]   next_note_r;

  // emitter
  logic [1:0]          cnt_r;
  logic [7:0]          out_byte_r;
  logic [6:0]          out_key_r;
  logic [6:0]          out_note_r;
  logic                out_kind_r;
  logic                out_last_r;
  logic [7:0]          pitch_r;
  logic [7:0]          velb_r;
  logic                emit_free;

  key_entry_t cur;
  logic       map_bit;
  logic       note_ok;
  logic       set_map;
  logic       emit_rec;
  logic       emit_midi;
  logic       learn_start;
  logic       emits;
  logic [7:0] adv_n;
  logic [7:0] status_b;
  logic [7:0] pitch_b;

  assign s1_a    = KEY_W'(s1_key_r);
  assign cur     = s1_hit_r ? fwd_r
                 : ((s1_key_ok_r && vld_r[s1_a]) ? mem_rd_r : '0);
  assign map_bit = s1_key_ok_r && mapped_r[s1_a];
  assign note_ok = {1'b0, s1_note_r} < 8'(NOTE_COUNT);

  always_comb begin
    mem_we      = 1'b0;
    wr_data     = cur;
    set_map     = 1'b0;
    emit_rec    = 1'b0;
    emit_midi   = 1'b0;
    learn_start = 1'b0;
    unique case (s1_mode_r)
      MODE_LEARN: learn_start = 1'b1;
      MODE_LOAD: begin
        if (s1_key_ok_r && note_ok) begin
          mem_we       = 1'b1;
          wr_data.note = s1_note_r;
          set_map      = 1'b1;
        end
      end
      MODE_SAMPLE: begin
        if (s1_key_ok_r && (cur.level != s1_lvl_r)) begin
          mem_we        = 1'b1;
          wr_data.level = s1_lvl_r;
          if (learning_r) begin
            if (s1_lvl_r && !map_bit) begin
              wr_data.note = next_note_r;
              set_map      = 1'b1;
              emit_rec     = 1'b1;
            end
          end else if (map_bit) begin
            emit_midi = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // next learned note, skipping the three reserved notes in order
  always_comb begin
    adv_n = {1'b0, next_note_r} + 8'd1;
    if (adv_n == SKIP_NOTE_A) adv_n = adv_n + 8'd1;
    if (adv_n == SKIP_NOTE_B) adv_n = adv_n + 8'd1;
    if (adv_n == SKIP_NOTE_C) adv_n = adv_n + 8'd1;
  end

  assign status_b  = (s1_lvl_r ? STATUS_NOTE_ON : STATUS_NOTE_OFF) | {4'd0, chan_r};
  assign pitch_b   = {1'b0, cur.note} + PITCH_OFFSET;
  assign emits     = emit_rec || emit_midi;
  assign emit_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign s1_fire   = s1_v_r && (!emits || emit_free);
  assign in_tready = !s1_v_r || s1_fire;

  // memory: read on accept, write back from the modify stage
  always_ff @(posedge clk) begin
    if (s1_fire && mem_we) mem[s1_a] <= wr_data;
    if (in_acc && in_key_ok) mem_rd_r <= mem[in_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      mapped_r <= '0;
    end else if (s1_fire) begin
      if (mem_we) vld_r[s1_a] <= 1'b1;
      if (learn_start) mapped_r <= '0;
      else if (set_map) mapped_r[s1_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  // a write leaving now is not seen by the read issued at the same edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r   <= in_tuser;
      s1_key_r    <= in_key;
      s1_lvl_r    <= in_lvl;
      s1_note_r   <= in_note;
      s1_key_ok_r <= in_key_ok;
      s1_hit_r    <= s1_fire && mem_we && in_key_ok && (s1_key_r == in_key);
      fwd_r       <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_r  <= 1'b0;
      next_note_r <= '0;
    end else if (s1_fire) begin
      if (learn_start) begin
        learning_r  <= 1'b1;
        next_note_r <= '0;
      end else if (emit_rec) begin
        next_note_r <= adv_n[6:0];
        if (adv_n >= 8'(NOTE_COUNT)) learning_r <= 1'b0;
      end
    end
  end

  // output sequencer: cnt_r is the number of words still to go, current one included
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (s1_fire && emits) begin
      cnt_r <= emit_midi ? 2'd3 : 2'd1;
    end else if (out_tvalid && out_tready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emits) begin
      out_kind_r <= emit_rec ? KIND_RECORD : KIND_MIDI;
      out_last_r <= emit_rec;
      out_byte_r <= emit_rec ? 8'd0 : status_b;
      out_key_r  <= emit_rec ? s1_key_r : 7'd0;
      out_note_r <= emit_rec ? next_note_r : 7'd0;
      pitch_r    <= pitch_b;
      velb_r     <= {1'b0, vel_r};
    end else if (out_tvalid && out_tready) begin
      if (cnt_r == 2'd3) begin
        out_byte_r <= pitch_r;
      end else if (cnt_r == 2'd2) begin
        out_byte_r <= velb_r;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = {2'b00, out_note_r, out_key_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (cnt_r == 2'd1)))
    else $error("tlast does not match the final word of a burst");

  a_burst_is_midi: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd3 || cnt_r == 2'd2) |-> (out_kind_r == KIND_MIDI))
    else $error("multi-word burst carrying a mapping record");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && emits) |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_tready)))
    else $error("new event loaded over a pending output word");

  a_learn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    learning_r |-> ({1'b0, next_note_r} < 8'(NOTE_COUNT)))
    else $error("learning with next note out of range");

  a_state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_fire) |=> (s1_v_r && $stable(s1_key_r) && $stable(mapped_r)))
    else $error("modify stage changed while stalled");

endmodule
